[src/bfie_pkg.sv]
// ----------------------------------------------------------------------------
// bfie_pkg
// types, constants and helpers shared by the bit field insert/extract store
// ----------------------------------------------------------------------------
package bfie_pkg;

  localparam int START_W   = 12;
  localparam int WIDTH_W   = 6;
  localparam int LEN_W     = 13;
  localparam int DATA_W    = 32;
  localparam int WORD_W    = 7;   // 32-bit word index within the addressable bit range
  localparam int OFF_W     = 5;   // bit offset within a 32-bit word
  localparam int FIELD_MAX = 32;

  // words reachable by any start bit plus the word a field may spill into
  localparam int REACH_WORDS = (1 << START_W) / DATA_W + 1;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

  typedef enum logic [1:0] {
    KIND_READ,
    KIND_WRITE,
    KIND_REJECT
  } kind_t;

  // one classified request as it travels from the front to the back
  typedef struct packed {
    kind_t              kind;
    logic [WORD_W-1:0]  word;
    logic [OFF_W-1:0]   off;
    logic [DATA_W-1:0]  mask;
    logic [DATA_W-1:0]  value;
  } job_t;

  // low w bits set, w in 0..32
  function automatic logic [DATA_W-1:0] field_mask(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] sh;
    sh = WIDTH_W'(FIELD_MAX) - w;
    return {DATA_W{1'b1}} >> sh;
  endfunction

endpackage

[src/bfie_front.sv]
// ----------------------------------------------------------------------------
// bfie_front
// takes request transfers, runs the range checks and builds a job
// ----------------------------------------------------------------------------
module bfie_front #(
  parameter int STORE_BYTES = 512
) (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [bfie_pkg::START_W-1:0]  start_bit,
  input  logic [bfie_pkg::WIDTH_W-1:0]  field_width,
  input  logic [bfie_pkg::DATA_W-1:0]   write_value,
  input  logic [bfie_pkg::LEN_W-1:0]    bit_length,
  input  logic                          clearing,
  input  logic                          q_full,
  output logic                          q_push,
  output bfie_pkg::job_t                q_job
);
  import bfie_pkg::*;

  localparam longint CAP_BITS = longint'(STORE_BYTES) * 8;
  localparam logic [LEN_W-1:0] CAP_LEN =
    (CAP_BITS > 64'd8191) ? {LEN_W{1'b1}} : LEN_W'(CAP_BITS);

  logic [LEN_W-1:0]   eff_len;
  logic [LEN_W-1:0]   start_x;
  logic [LEN_W-1:0]   end_bit;
  logic [LEN_W-1:0]   room;
  logic               width_ok;
  logic               start_ok;
  logic [WIDTH_W-1:0] eff_w;

  assign in_stall = q_full || clearing;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    eff_len  = (bit_length < CAP_LEN) ? bit_length : CAP_LEN;
    start_x  = {1'b0, start_bit};
    end_bit  = start_x + LEN_W'(field_width);
    room     = eff_len - start_x;
    width_ok = (field_width != '0) && (field_width <= WIDTH_W'(FIELD_MAX));
    start_ok = start_x < eff_len;
    // writes running past the end are clamped to the end
    eff_w    = (end_bit > eff_len) ? room[WIDTH_W-1:0] : field_width;

    q_job.word  = start_bit[START_W-1:OFF_W];
    q_job.off   = start_bit[OFF_W-1:0];
    q_job.mask  = field_mask(eff_w);
    q_job.value = write_value;
    if (!width_ok || !start_ok) begin
      q_job.kind = KIND_REJECT;
    end else if (op == OP_WRITE) begin
      q_job.kind = KIND_WRITE;
    end else if (end_bit <= eff_len) begin
      q_job.kind = KIND_READ;
    end else begin
      q_job.kind = KIND_REJECT;
    end
  end

endmodule

[src/bfie_queue.sv]
// ----------------------------------------------------------------------------
// bfie_queue
// two-entry job queue between the front and the back
// ----------------------------------------------------------------------------
module bfie_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bfie_pkg::job_t  push_job,
  output logic            full,
  output logic            valid,
  input  logic            pop,
  output bfie_pkg::job_t  head
);
  import bfie_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/bfie_back.sv]
// ----------------------------------------------------------------------------
// bfie_back
// banked word store with read-modify-write sequencer and result register
// ----------------------------------------------------------------------------
module bfie_back #(
  parameter int STORE_BYTES = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  bfie_pkg::job_t               q_job,
  output logic                         q_pop,
  output logic                         clearing,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bfie_pkg::DATA_W-1:0]  read_value,
  output logic                         accepted
);
  import bfie_pkg::*;

  localparam int NWORDS_RAW = (STORE_BYTES + 3) / 4 + 1;
  localparam int NWORDS     = (NWORDS_RAW < REACH_WORDS) ? NWORDS_RAW : REACH_WORDS;
  localparam int BANK_DEPTH = (NWORDS + 1) / 2;
  localparam int IDXW       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_ACCESS = 2'd2;

  // even and odd 32-bit words, so a field's two words sit in different banks
  logic [DATA_W-1:0] even_mem [BANK_DEPTH];
  logic [DATA_W-1:0] odd_mem  [BANK_DEPTH];

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [IDXW-1:0]   clr_idx;
  job_t              cur;
  logic [DATA_W-1:0] even_q;
  logic [DATA_W-1:0] odd_q;

  logic [IDXW-1:0]   rd_even_addr;
  logic [IDXW-1:0]   rd_odd_addr;
  logic [IDXW-1:0]   wr_even_addr;
  logic [IDXW-1:0]   wr_odd_addr;
  logic [WORD_W-1:0] rd_even_w;
  logic [WORD_W-1:0] wr_even_w;
  logic              rd_en;
  logic              out_free;
  logic              finish;

  logic [2*DATA_W-1:0] window;
  logic [2*DATA_W-1:0] m64;
  logic [2*DATA_W-1:0] v64;
  logic [2*DATA_W-1:0] merged;
  logic [2*DATA_W-1:0] shifted;
  logic [DATA_W-1:0]   extract;
  logic [DATA_W-1:0]   lo_new;
  logic [DATA_W-1:0]   hi_new;
  logic                lo_we;
  logic                hi_we;

  logic              even_we;
  logic              odd_we;
  logic [IDXW-1:0]   even_wa;
  logic [IDXW-1:0]   odd_wa;
  logic [DATA_W-1:0] even_wd;
  logic [DATA_W-1:0] odd_wd;

  assign clearing = (state == ST_CLEAR);
  assign out_free = !out_valid || !out_stall;
  assign rd_en    = (state == ST_IDLE) && q_valid;
  assign q_pop    = rd_en;
  assign finish   = (state == ST_ACCESS) && out_free;

  // for a field at words w and w+1: even bank read at (w+1)/2 rounded down, odd bank at w/2 rounded down
  assign rd_even_w    = {1'b0, q_job.word[WORD_W-1:1]} + WORD_W'(q_job.word[0]);
  assign rd_even_addr = IDXW'(rd_even_w);
  assign rd_odd_addr  = IDXW'({1'b0, q_job.word[WORD_W-1:1]});
  assign wr_even_w    = {1'b0, cur.word[WORD_W-1:1]} + WORD_W'(cur.word[0]);
  assign wr_even_addr = IDXW'(wr_even_w);
  assign wr_odd_addr  = IDXW'({1'b0, cur.word[WORD_W-1:1]});

  always_comb begin
    window  = cur.word[0] ? {even_q, odd_q} : {odd_q, even_q};
    m64     = {{DATA_W{1'b0}}, cur.mask} << cur.off;
    v64     = {{DATA_W{1'b0}}, cur.value} << cur.off;
    merged  = (window & ~m64) | (v64 & m64);
    shifted = window >> cur.off;
    extract = shifted[DATA_W-1:0] & cur.mask;
    lo_new  = merged[DATA_W-1:0];
    hi_new  = merged[2*DATA_W-1:DATA_W];
    lo_we   = finish && (cur.kind == KIND_WRITE) && (m64[DATA_W-1:0] != '0);
    hi_we   = finish && (cur.kind == KIND_WRITE) && (m64[2*DATA_W-1:DATA_W] != '0);
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      even_we = 1'b1;
      odd_we  = 1'b1;
      even_wa = clr_idx;
      odd_wa  = clr_idx;
      even_wd = '0;
      odd_wd  = '0;
    end else begin
      even_wa = wr_even_addr;
      odd_wa  = wr_odd_addr;
      if (cur.word[0]) begin
        odd_we  = lo_we;
        odd_wd  = lo_new;
        even_we = hi_we;
        even_wd = hi_new;
      end else begin
        even_we = lo_we;
        even_wd = lo_new;
        odd_we  = hi_we;
        odd_wd  = hi_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (even_we) begin
      even_mem[even_wa] <= even_wd;
    end
    if (odd_we) begin
      odd_mem[odd_wa] <= odd_wd;
    end
    if (rd_en) begin
      even_q <= even_mem[rd_even_addr];
      odd_q  <= odd_mem[rd_odd_addr];
      cur    <= q_job;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == IDXW'(BANK_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          state_next = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + IDXW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      read_value <= (cur.kind == KIND_READ) ? extract : '0;
      accepted   <= (cur.kind != KIND_REJECT);
    end
  end

endmodule

[src/bit_field_insert_extract_store.sv]
// ----------------------------------------------------------------------------
// bit_field_insert_extract_store
// bit array with field write (insert) and field read (extract) of 1 to 32 bits
// ----------------------------------------------------------------------------
//
//  channel   signals                                                     direction
//  -------   ----------------------------------------------------------  ---------
//  request   in_valid/in_stall, op, start_bit, field_width, write_value  in
//  result    out_valid/out_stall, read_value, accepted                   out
//  config    cfg_write, cfg_data (bit_length)                            in
//
//  the back end takes one request at a time over its single bank port pair: it
//  reads two banked words in ST_IDLE, then extracts or merges and writes back in
//  ST_ACCESS, holding while the result register is stalled; after reset a clearing
//  pass zeroes the store, one word per bank a cycle, and no request transfers then
//  a two-entry queue lets requests be taken while the back end or result waits
//  in_stall rises only when the queue is full or the clearing pass runs
//  rst is synchronous and active high; bit_length resets to 4096
//
module bit_field_insert_extract_store #(
  parameter int STORE_BYTES = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bfie_pkg::LEN_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [bfie_pkg::START_W-1:0]  start_bit,
  input  logic [bfie_pkg::WIDTH_W-1:0]  field_width,
  input  logic [bfie_pkg::DATA_W-1:0]   write_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bfie_pkg::DATA_W-1:0]   read_value,
  output logic                          accepted
);
  import bfie_pkg::*;

  logic [LEN_W-1:0] bit_length;
  logic             clearing;
  logic             q_full;
  logic             q_push;
  logic             q_valid;
  logic             q_pop;
  job_t             push_job;
  job_t             head_job;

  // length register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_length <= LEN_RESET;
    end else if (cfg_write) begin
      bit_length <= cfg_data;
    end
  end

  // front: range checks, clamping, field mask
  bfie_front #(
    .STORE_BYTES (STORE_BYTES)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .start_bit   (start_bit),
    .field_width (field_width),
    .write_value (write_value),
    .bit_length  (bit_length),
    .clearing    (clearing),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  // decouples request transfers from the store sequencer
  bfie_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .head     (head_job)
  );

  // back: banked store, read-modify-write, result register
  bfie_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .accepted   (accepted)
  );

endmodule

[dv/bfie_store_checker.sv]
// ----------------------------------------------------------------------------
// bfie_store_checker
// watches the request, result and config ports of the bit field store, keeps
// a shadow copy of the bit array and compares every result transfer in order
// ----------------------------------------------------------------------------
module bfie_store_checker #(
  parameter int STORE_BYTES = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bfie_pkg::LEN_W-1:0]    cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          op,
  input  logic [bfie_pkg::START_W-1:0]  start_bit,
  input  logic [bfie_pkg::WIDTH_W-1:0]  field_width,
  input  logic [bfie_pkg::DATA_W-1:0]   write_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [bfie_pkg::DATA_W-1:0]   read_value,
  input  logic                          accepted,
  output int                            fail_count,
  output int                            outstanding
);
  import bfie_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              ok;
  } field_result_t;

  logic [7:0]      shadow_store [STORE_BYTES];
  logic [LEN_W-1:0] shadow_length;
  field_result_t   field_results_due [$];

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    $display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
    fail_count++;
  endtask

  // applies one request to the shadow store and returns what the block must answer
  function automatic field_result_t apply_field_access(
      input logic wr, input logic [START_W-1:0] start, input logic [WIDTH_W-1:0] width,
      input logic [DATA_W-1:0] value);
    int unsigned   len_eff;
    int unsigned   first;
    int unsigned   n;
    int unsigned   pos;
    int unsigned   k;
    field_result_t res;
    res     = '0;
    len_eff = (shadow_length > STORE_BYTES * 8) ? STORE_BYTES * 8 : shadow_length;
    first   = start;
    n       = width;
    if (n >= 1 && n <= FIELD_MAX && first < len_eff) begin
      if (wr == OP_WRITE) begin
        // clamp at the end so bits past the length stay untouched
        if (first + n > len_eff) n = len_eff - first;
        for (k = 0; k < n; k++) begin
          pos = first + k;
          shadow_store[pos / 8][pos % 8] = value[k];
        end
        res.ok = 1'b1;
      end else if (first + n <= len_eff) begin
        for (k = 0; k < n; k++) begin
          pos = first + k;
          res.value[k] = shadow_store[pos / 8][pos % 8];
        end
        res.ok = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    field_result_t want;
    if (rst) begin
      foreach (shadow_store[i]) shadow_store[i] = '0;
      shadow_length = LEN_RESET;
      field_results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (field_results_due.size() == 0) begin
          report_mismatch("result transfer with none due, read_value", '0, read_value);
        end else begin
          want = field_results_due.pop_front();
          if (read_value !== want.value) report_mismatch("read_value", want.value, read_value);
          if (accepted !== want.ok) report_mismatch("accepted", DATA_W'(want.ok),
                                                    DATA_W'(accepted));
        end
      end
      if (cfg_write) shadow_length = cfg_data;
      if (in_valid && !in_stall)
        field_results_due.push_back(apply_field_access(op, start_bit, field_width,
                                                       write_value));
    end
    outstanding = field_results_due.size();
  end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// drives field reads and writes into the bit field insert/extract store under
// random idling and stalls, across several bit_length settings; the checker
// beside the block predicts each result and counts mismatches
// ----------------------------------------------------------------------------
module tb;
  import bfie_pkg::*;

  localparam int STORE_BYTES    = 512;
  localparam int STORE_BITS     = STORE_BYTES * 8;
  // longest quiet stretch in a correct run is the receiver hold-off below,
  // then the clearing pass and config pauses; several times over that
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_write   = 1'b0;
  logic [LEN_W-1:0]   cfg_data    = '0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic               op          = OP_READ;
  logic [START_W-1:0] start_bit   = '0;
  logic [WIDTH_W-1:0] field_width = '0;
  logic [DATA_W-1:0]  write_value = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [DATA_W-1:0]  read_value;
  logic               accepted;

  int fail_count;
  int outstanding;
  int quiet_cycles;

  // gaps_off and rx_hold_req are shared between the sender and the receiver process
  bit          gaps_off;      // no idling on either side while set
  bit          rx_hold_req;   // ask the receiver for one long hold-off
  int unsigned cur_len = LEN_RESET;

  bit_field_insert_extract_store #(
    .STORE_BYTES(STORE_BYTES)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .start_bit   (start_bit),
    .field_width (field_width),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value),
    .accepted    (accepted)
  );

  bfie_store_checker #(
    .STORE_BYTES(STORE_BYTES)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .start_bit   (start_bit),
    .field_width (field_width),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value),
    .accepted    (accepted),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog: any cycle without a transfer on either channel counts
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result side: a random stall before each transfer, or one long hold-off
  // on request so the two-entry queue fills and the block stalls its input
  initial begin
    int unsigned hold;
    forever begin
      if (rx_hold_req) begin
        hold        = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else begin
        hold = gaps_off ? 0 : $urandom_range(0, 15);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      // one result transfer
      do @(posedge clk); while (!out_valid);
    end
  end

  // one request transfer; valid stays high into the next item when no gap is drawn
  task automatic send_request(input logic wr, input int unsigned start,
                              input int unsigned width, input logic [DATA_W-1:0] value);
    int unsigned gap;
    gap = gaps_off ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= wr;
    start_bit   <= START_W'(start);
    field_width <= WIDTH_W'(width);
    write_value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and wait for every due result, then a few cycles of slack
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_length(input int unsigned len);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= LEN_W'(len);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_len = len;
  endtask

  // mostly in-range fields, biased toward the low bytes (so reads hit earlier
  // writes) and toward the end of the length; about one in ten is pure noise
  task automatic random_requests(input int unsigned count);
    int unsigned       len_eff;
    int unsigned       start;
    int unsigned       width;
    int unsigned       pick;
    logic              wr;
    logic [DATA_W-1:0] value;
    len_eff = (cur_len > STORE_BITS) ? STORE_BITS : cur_len;
    repeat (count) begin
      wr    = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
      value = $urandom;
      pick  = $urandom_range(0, 9);
      width = $urandom_range(1, FIELD_MAX);
      if (pick == 0 || len_eff == 0) begin
        start = $urandom_range(0, (1 << START_W) - 1);
        width = $urandom_range(0, (1 << WIDTH_W) - 1);
      end else if (pick <= 3) begin
        start = (len_eff > 48) ? len_eff - $urandom_range(1, 48) : $urandom_range(0, len_eff - 1);
      end else if (pick <= 6) begin
        start = $urandom_range(0, ((len_eff < 256) ? len_eff : 256) - 1);
      end else begin
        start = $urandom_range(0, len_eff - 1);
      end
      send_request(wr, start, width, value);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset length; the clearing pass holds in_stall first
    send_request(OP_WRITE, 0, 32, 32'hFFFF_FFFF);
    send_request(OP_READ, 0, 32, 32'h0);
    send_request(OP_WRITE, 3, 2, 32'h0);              // stays inside one byte
    send_request(OP_READ, 0, 8, 32'h0);
    send_request(OP_WRITE, 7, 32, 32'h1234_5678);     // spans five bytes
    send_request(OP_READ, 7, 32, 32'h0);
    send_request(OP_READ, 32, 8, 32'h0);
    send_request(OP_WRITE, 100, 17, 32'hFFFF_FFFF);   // high value bits ignored
    send_request(OP_READ, 96, 32, 32'h0);
    send_request(OP_WRITE, 4064, 32, 32'hA5A5_A5A5);  // ends exactly at the length
    send_request(OP_READ, 4064, 32, 32'h0);
    send_request(OP_READ, 4065, 32, 32'h0);           // read past end
    send_request(OP_WRITE, 4090, 32, 32'hFFFF_FFFF);  // write clamped at the end
    send_request(OP_READ, 4090, 6, 32'h0);
    send_request(OP_WRITE, 4095, 1, 32'h0);           // last bit, highest start
    send_request(OP_READ, 4088, 8, 32'h0);
    send_request(OP_WRITE, 5, 0, 32'hFFFF_FFFF);      // zero width
    send_request(OP_READ, 0, 0, 32'h0);
    send_request(OP_READ, 0, 33, 32'h0);              // width just over the limit
    send_request(OP_WRITE, 0, 63, 32'h0);             // widest encodable width
    send_request(OP_READ, 0, 32, 32'h0);

    // short length that is not a byte multiple
    set_length(100);
    send_request(OP_WRITE, 90, 20, 32'h000F_FFFF);
    send_request(OP_READ, 96, 4, 32'h0);
    send_request(OP_READ, 96, 5, 32'h0);
    send_request(OP_WRITE, 100, 1, 32'h1);            // start at the length

    // zero length rejects everything
    set_length(0);
    send_request(OP_WRITE, 0, 1, 32'h1);
    send_request(OP_READ, 0, 1, 32'h0);

    // length above the store saturates to the store size
    set_length((1 << LEN_W) - 1);
    send_request(OP_READ, 4064, 32, 32'h0);

    // random part over several lengths
    set_length(STORE_BITS);
    random_requests(70);
    gaps_off = 1'b1;                                  // a stretch with no idling
    random_requests(40);
    rx_hold_req = 1'b1;                               // long receiver hold-off
    random_requests(60);
    gaps_off = 1'b0;
    set_length((1 << LEN_W) - 1);
    random_requests(60);
    set_length($urandom_range(1, STORE_BITS - 1));
    random_requests(70);
    set_length(0);
    random_requests(10);
    set_length(37);
    random_requests(40);
    set_length(STORE_BITS);
    random_requests(50);

    wait_idle();
    repeat (12) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
